>>> rtl/core/tfp_pkg.sv
`default_nettype none

package tfp_pkg;

    localparam int unsigned CFG_W      = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned LEN_W      = 5;
    // highest payload byte any decode reads is byte 13
    localparam int unsigned STORE_BYTES = 14;
    localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(4);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_X      = 8'h58;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SYNC1 = 2'd1,
        PH_SYNC2 = 2'd2,
        PH_DATA  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        KIND_ATT    = 3'd0,
        KIND_STAT   = 3'd1,
        KIND_GPS    = 3'd2,
        KIND_EXTRA  = 3'd3,
        KIND_ORIGIN = 3'd4,
        KIND_NAV    = 3'd5
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEN_GPS    = 3'd0,
        CFG_LEN_ATT    = 3'd1,
        CFG_LEN_STAT   = 3'd2,
        CFG_LEN_ORIGIN = 3'd3,
        CFG_LEN_NAV    = 3'd4,
        CFG_LEN_EXTRA  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [LEN_W-1:0] len_gps;
        logic [LEN_W-1:0] len_att;
        logic [LEN_W-1:0] len_stat;
        logic [LEN_W-1:0] len_origin;
        logic [LEN_W-1:0] len_nav;
        logic [LEN_W-1:0] len_extra;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         frame_kind;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] value_c;
        logic [7:0]         value_d;
        logic [5:0]         value_e;
        logic [1:0]         value_f;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/tfp_byte_if.sv
`default_nettype none

interface tfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tfp_result_if.sv
`default_nettype none

interface tfp_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_kind;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic [7:0]         value_d;
    logic [5:0]         value_e;
    logic [1:0]         value_f;

    modport source (output valid, output frame_kind, output value_a, output value_b,
                    output value_c, output value_d, output value_e, output value_f,
                    input ready);
    modport sink   (input valid, input frame_kind, input value_a, input value_b,
                    input value_c, input value_d, input value_e, input value_f,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/telemetry_frame_parser_unit.sv
`default_nettype none

// Telemetry frame parser: one received byte per cycle while rx.ready is high.
// A result is registered in the output buffer when its checksum beat is taken.
// Throughput: one byte per clock; a two-deep output buffer keeps input
// flowing while the sink stalls, and input stops only when both slots are full.
// Reset: hunts for sync, payload store zeroed, frame lengths at their defaults.
module telemetry_frame_parser_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [tfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tfp_pkg::CFG_W-1:0]      cfg_wdata,
    tfp_byte_if.sink                            rx,
    tfp_result_if.source                        result
);
    import tfp_pkg::*;

    cfg_t    cfg;
    logic    beat;
    logic    can_take;
    logic    res_valid;
    result_t res;
    result_t out_data;

    assign rx.ready = can_take;
    assign beat     = rx.valid & can_take;

    tfp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tfp_frame_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .beat      (beat),
        .rx_byte   (rx.rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    tfp_out_buf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .can_take  (can_take),
        .out_valid (result.valid),
        .out_data  (out_data),
        .out_ready (result.ready)
    );

    assign result.frame_kind = out_data.frame_kind;
    assign result.value_a    = out_data.value_a;
    assign result.value_b    = out_data.value_b;
    assign result.value_c    = out_data.value_c;
    assign result.value_d    = out_data.value_d;
    assign result.value_e    = out_data.value_e;
    assign result.value_f    = out_data.value_f;

endmodule

`default_nettype wire

>>> rtl/core/tfp_cfg_regs.sv
`default_nettype none

module tfp_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [tfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tfp_pkg::CFG_W-1:0]      cfg_wdata,
    output tfp_pkg::cfg_t                       cfg
);
    import tfp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LEN_GPS:    cfg_next.len_gps    = cfg_wdata;
                CFG_LEN_ATT:    cfg_next.len_att    = cfg_wdata;
                CFG_LEN_STAT:   cfg_next.len_stat   = cfg_wdata;
                CFG_LEN_ORIGIN: cfg_next.len_origin = cfg_wdata;
                CFG_LEN_NAV:    cfg_next.len_nav    = cfg_wdata;
                CFG_LEN_EXTRA:  cfg_next.len_extra  = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.len_gps    <= LEN_W'(18);
            cfg_reg.len_att    <= LEN_W'(10);
            cfg_reg.len_stat   <= LEN_W'(11);
            cfg_reg.len_origin <= LEN_W'(18);
            cfg_reg.len_nav    <= LEN_W'(10);
            cfg_reg.len_extra  <= LEN_W'(10);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/core/tfp_frame_fsm.sv
`default_nettype none

module tfp_frame_fsm (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tfp_pkg::cfg_t  cfg,
    input  wire logic           beat,
    input  wire logic [7:0]     rx_byte,
    output logic                res_valid,
    output tfp_pkg::result_t    res
);
    import tfp_pkg::*;

    phase_t           phase_reg, phase_next;
    kind_t            kind_reg, kind_next;
    logic [LEN_W-1:0] plen_reg, plen_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [7:0]       store_reg [STORE_BYTES];
    logic [7:0]       store_next [STORE_BYTES];
    logic [LEN_W-1:0] sel_len;
    logic             kind_ok;
    kind_t            sel_kind;

    // type byte to kind and configured frame length
    always_comb
    begin
        kind_ok  = 1'b1;
        sel_kind = KIND_ATT;
        sel_len  = cfg.len_att;
        unique case (rx_byte)
            CH_G:    begin sel_kind = KIND_GPS;    sel_len = cfg.len_gps;    end
            CH_A:    begin sel_kind = KIND_ATT;    sel_len = cfg.len_att;    end
            CH_S:    begin sel_kind = KIND_STAT;   sel_len = cfg.len_stat;   end
            CH_O:    begin sel_kind = KIND_ORIGIN; sel_len = cfg.len_origin; end
            CH_N:    begin sel_kind = KIND_NAV;    sel_len = cfg.len_nav;    end
            CH_X:    begin sel_kind = KIND_EXTRA;  sel_len = cfg.len_extra;  end
            default: kind_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        plen_next  = plen_reg;
        idx_next   = idx_reg;
        store_next = store_reg;
        res_valid  = 1'b0;
        res        = '0;

        if (beat)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == CH_DOLLAR)
                        phase_next = PH_SYNC1;
                end
                PH_SYNC1:
                begin
                    phase_next = (rx_byte == CH_T) ? PH_SYNC2 : PH_IDLE;
                end
                PH_SYNC2:
                begin
                    if (kind_ok)
                    begin
                        kind_next  = sel_kind;
                        plen_next  = (sel_len >= HDR_LEN) ? sel_len - HDR_LEN : '0;
                        idx_next   = '0;
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_DATA:
                begin
                    if (idx_reg < plen_reg)
                    begin
                        for (int i = 0; i < STORE_BYTES; i++)
                        begin
                            if (idx_reg == LEN_W'(i))
                                store_next[i] = rx_byte;
                        end
                        idx_next = idx_reg + LEN_W'(1);
                    end
                    else
                    begin
                        // checksum beat: decode, then drop back to hunting
                        res.frame_kind = kind_reg[1:0];
                        case (kind_reg)
                            KIND_ATT:
                            begin
                                res.value_a = 32'(signed'({store_reg[1], store_reg[0]}));
                                res.value_b = 32'(signed'({store_reg[3], store_reg[2]}));
                                res.value_c = 32'(signed'({store_reg[5], store_reg[4]}));
                            end
                            KIND_STAT:
                            begin
                                res.value_a = {16'd0, store_reg[1], store_reg[0]};
                                res.value_b = {24'd0, store_reg[4]};
                                res.value_c = {26'd0, store_reg[6][7:2]};
                            end
                            KIND_GPS:
                            begin
                                res.value_a = {store_reg[3], store_reg[2],
                                               store_reg[1], store_reg[0]};
                                res.value_b = {store_reg[7], store_reg[6],
                                               store_reg[5], store_reg[4]};
                                res.value_c = {store_reg[12], store_reg[11],
                                               store_reg[10], store_reg[9]};
                                res.value_d = store_reg[8];
                                res.value_e = store_reg[13][7:2];
                                res.value_f = store_reg[13][1:0];
                            end
                            KIND_EXTRA:
                            begin
                                res.value_a = {16'd0, store_reg[1], store_reg[0]};
                                res.value_b = {24'd0, store_reg[2]};
                            end
                            default:
                            begin
                                res = '0;
                            end
                        endcase
                        res_valid  = (kind_reg == KIND_ATT) || (kind_reg == KIND_STAT) ||
                                     (kind_reg == KIND_GPS) || (kind_reg == KIND_EXTRA);
                        phase_next = PH_IDLE;
                        idx_next   = '0;
                        for (int i = 0; i < STORE_BYTES; i++)
                            store_next[i] = 8'd0;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kind_reg  <= KIND_ATT;
            plen_reg  <= '0;
            idx_reg   <= '0;
            for (int i = 0; i < STORE_BYTES; i++)
                store_reg[i] <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            plen_reg  <= plen_next;
            idx_reg   <= idx_next;
            store_reg <= store_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tfp_out_buf.sv
`default_nettype none

module tfp_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              res_valid,
    input  wire tfp_pkg::result_t  res,
    output logic                   can_take,
    output logic                   out_valid,
    output tfp_pkg::result_t       out_data,
    input  wire logic              out_ready
);
    import tfp_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    take;

    assign take     = main_valid_reg & out_ready;
    // skid slot absorbs one result while the sink stalls
    assign can_take = !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = res_valid;
                if (res_valid)
                    main_next = res;
            end
        end
        else if (!main_valid_reg)
        begin
            main_valid_next = res_valid;
            if (res_valid)
                main_next = res;
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

`default_nettype wire
